// File: hw/rtl/assert_macros.svh
// Assertion helpers, clocked on clock and disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every edge.
`define PTT_ASSERT(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define PTT_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent implies consequent in the next cycle.
`define PTT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/ptt_pkg.sv
package ptt_pkg;

   localparam int TABLE_ENTRIES   = 256;
   localparam int IDX_W           = $clog2(TABLE_ENTRIES);
   localparam int ALPHA_FRAC_BITS = 8;
   localparam int CHAN_W          = 8;
   localparam int NUM_CHAN        = 4;
   localparam int ENTRY_W         = CHAN_W * NUM_CHAN;
   localparam int SUM_W           = 17;
   localparam int WORD_W          = ENTRY_W + NUM_CHAN * SUM_W;
   localparam int DIV_W           = SUM_W + ALPHA_FRAC_BITS;
   localparam int DVSR_W          = IDX_W + 1;
   localparam int XQ_W            = CHAN_W + ALPHA_FRAC_BITS;
   localparam int CNT_W           = $clog2(DIV_W);
   localparam int ALPHA_LEVELS    = 1 << CHAN_W;
   // 255 * ln(256) < 2^11
   localparam int THR_W           = ALPHA_FRAC_BITS + 11;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef logic [THR_W-1:0] thr_arr_type [ALPHA_LEVELS];

   typedef struct packed {
      logic                               start;
      logic [DVSR_W-1:0]                  divisor;
      logic [NUM_CHAN-1:0][DIV_W-1:0]     dividend;
   } div_req_type;

   typedef struct packed {
      logic                               done;
      logic [NUM_CHAN-1:0][CHAN_W-1:0]    chan;
   } div_rsp_type;

   // Opacity thresholds: ceil(2^F * 255 * -ln(1 - k * 2^-8)), i.e. the log of
   // 256 over (256 - k); k * 2^-8 is exact in floating point.
   function automatic thr_arr_type build_alpha_thresh();
      thr_arr_type t;
      real         scale;
      real         v;
      scale = real'(longint'(255) << ALPHA_FRAC_BITS);
      t[0]  = '0;
      for (int k = 1; k < ALPHA_LEVELS; k++) begin
         v    = $ceil(-scale * $ln(1.0 - real'(k) * 0.00390625));
         t[k] = THR_W'(longint'(v));
      end
      return t;
   endfunction

   localparam thr_arr_type ALPHA_THRESH = build_alpha_thresh();

endpackage

// File: hw/rtl/ptt_ram.sv
module ptt_ram
   #(parameter int WIDTH = 8,
     parameter int ADDR_W = 8)
   (input  logic              clock,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr_a,
    input  logic [ADDR_W-1:0] rd_addr_b,
    output logic [WIDTH-1:0]  rd_data_a,
    output logic [WIDTH-1:0]  rd_data_b);

   logic [WIDTH-1:0] mem_ff [1 << ADDR_W];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// File: hw/rtl/ptt_div.sv
module ptt_div
   import ptt_pkg::*;
   (input  logic        clock,
    input  logic        reset,
    input  div_req_type div_req,
    output div_rsp_type div_rsp);

   localparam logic [2:0] P_IDLE = 3'd0;
   localparam logic [2:0] P_DIV  = 3'd1;
   localparam logic [2:0] P_SAT  = 3'd2;
   localparam logic [2:0] P_SRCH = 3'd3;
   localparam logic [2:0] P_DONE = 3'd4;

   logic [2:0]        phase_ff, phase_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DVSR_W-1:0] dvsr_ff, dvsr_in;
   logic [DIV_W-1:0]  acc_ff [NUM_CHAN];
   logic [DIV_W-1:0]  acc_in [NUM_CHAN];
   logic [DVSR_W-1:0] rem_ff [NUM_CHAN];
   logic [DVSR_W-1:0] rem_in [NUM_CHAN];
   logic [CHAN_W-1:0] color_ff [NUM_CHAN-1];
   logic [CHAN_W-1:0] color_in [NUM_CHAN-1];
   logic [XQ_W-1:0]   xq_ff, xq_in;
   logic [CHAN_W-1:0] pos_ff, pos_in;
   logic [CHAN_W-1:0] mask_ff, mask_in;
   logic [DVSR_W:0]   rem_s [NUM_CHAN];
   logic              ge [NUM_CHAN];
   logic [XQ_W-1:0]   q_sat [NUM_CHAN];
   logic [CHAN_W-1:0] cand;

   always_comb begin
      for (int c = 0; c < NUM_CHAN; c++) begin
         rem_s[c] = {rem_ff[c], acc_ff[c][DIV_W-1]};
         ge[c]    = rem_s[c] >= {1'b0, dvsr_ff};
         q_sat[c] = (|acc_ff[c][DIV_W-1:XQ_W]) ? {XQ_W{1'b1}} : acc_ff[c][XQ_W-1:0];
      end
      cand = pos_ff | mask_ff;
   end

   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      dvsr_in  = dvsr_ff;
      xq_in    = xq_ff;
      pos_in   = pos_ff;
      mask_in  = mask_ff;
      acc_in   = acc_ff;
      rem_in   = rem_ff;
      color_in = color_ff;
      case (phase_ff)
         P_IDLE: begin
            if (div_req.start) begin
               dvsr_in = div_req.divisor;
               for (int c = 0; c < NUM_CHAN; c++) begin
                  acc_in[c] = div_req.dividend[c];
                  rem_in[c] = '0;
               end
               cnt_in   = CNT_W'(DIV_W - 1);
               phase_in = P_DIV;
            end
         end
         P_DIV: begin
            // one restoring step per lane
            for (int c = 0; c < NUM_CHAN; c++) begin
               rem_in[c] = ge[c] ? DVSR_W'(rem_s[c] - {1'b0, dvsr_ff})
                                 : DVSR_W'(rem_s[c]);
               acc_in[c] = {acc_ff[c][DIV_W-2:0], ge[c]};
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               phase_in = P_SAT;
            end
         end
         P_SAT: begin
            for (int c = 0; c < NUM_CHAN - 1; c++) begin
               color_in[c] = q_sat[c][XQ_W-1:ALPHA_FRAC_BITS];
            end
            xq_in    = q_sat[NUM_CHAN-1];
            pos_in   = '0;
            mask_in  = {1'b1, {(CHAN_W-1){1'b0}}};
            phase_in = P_SRCH;
         end
         P_SRCH: begin
            if (ALPHA_THRESH[cand] <= THR_W'(xq_ff)) begin
               pos_in = cand;
            end
            mask_in = mask_ff >> 1;
            if (mask_ff[0]) begin
               phase_in = P_DONE;
            end
         end
         P_DONE: begin
            phase_in = P_IDLE;
         end
         default: begin
            phase_in = P_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= P_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      dvsr_ff  <= dvsr_in;
      xq_ff    <= xq_in;
      pos_ff   <= pos_in;
      mask_ff  <= mask_in;
      acc_ff   <= acc_in;
      rem_ff   <= rem_in;
      color_ff <= color_in;
   end

   always_comb begin
      div_rsp.done = phase_ff == P_DONE;
      for (int c = 0; c < NUM_CHAN - 1; c++) begin
         div_rsp.chan[c] = color_ff[c];
      end
      div_rsp.chan[NUM_CHAN-1] = pos_ff;
   end

endmodule

// File: hw/rtl/preintegrated_transfer_table.sv
// Pre-integrated 1D transfer table. A load beat (opcode 0) writes one RGBA
// entry and the doubled trapezoid prefix integrals of all four channels; loads
// must come in ascending index order from zero and take one cycle each. A
// query beat (opcode 1) returns one result beat for the segment between the
// back and front samples: for equal samples the stored entry, otherwise the
// per-channel integral difference over twice the distance (colors clamped to
// 255) and an opacity from a 256-entry exponential threshold table. An
// equal-sample query goes from the read state straight to its result; an
// unequal one first waits on the 25-step bit-serial divider shared across the
// four channels plus an 8-step binary search of the opacity thresholds. Only
// one item is in flight at a time: req_stall stays high until the result beat
// is taken. All entries and integrals live in one memory with two registered
// read ports, so a query reads its low and high entries in the same cycle.
module preintegrated_transfer_table
   import ptt_pkg::*;
   (input  logic        clock,
    input  logic        reset,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic        req_opcode,
    input  logic [7:0]  req_entry_index,
    input  logic [7:0]  req_entry_red,
    input  logic [7:0]  req_entry_green,
    input  logic [7:0]  req_entry_blue,
    input  logic [7:0]  req_entry_alpha,
    input  logic [7:0]  req_back_sample,
    input  logic [7:0]  req_front_sample,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [7:0]  rsp_seg_red,
    output logic [7:0]  rsp_seg_green,
    output logic [7:0]  rsp_seg_blue,
    output logic [7:0]  rsp_seg_alpha);

`include "assert_macros.svh"

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [SUM_W-1:0]  sums_ff [NUM_CHAN];
   logic [SUM_W-1:0]  sums_in [NUM_CHAN];
   logic [ENTRY_W-1:0] prev_ff, prev_in;
   logic [DVSR_W-1:0] dvsr_ff, dvsr_in;
   logic              equal_ff, equal_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [NUM_CHAN-1:0][CHAN_W-1:0] seg_ff, seg_in;

   logic              accept;
   logic              load_acc;
   logic              query_acc;
   logic [IDX_W-1:0]  idx;
   logic [IDX_W-1:0]  back_idx;
   logic [IDX_W-1:0]  front_idx;
   logic [IDX_W-1:0]  lo_idx;
   logic [IDX_W-1:0]  hi_idx;
   logic [ENTRY_W-1:0] packed_entry;
   logic [WORD_W-1:0] wr_word;
   logic [WORD_W-1:0] rd_lo;
   logic [WORD_W-1:0] rd_hi;
   logic [SUM_W:0]    diff [NUM_CHAN];
   div_req_type       div_req;
   div_rsp_type       div_rsp;

   assign accept    = req_valid && !req_stall;
   assign load_acc  = accept && (req_opcode == OP_LOAD);
   assign query_acc = accept && (req_opcode == OP_QUERY);
   assign idx       = req_entry_index[IDX_W-1:0];
   assign back_idx  = req_back_sample[IDX_W-1:0];
   assign front_idx = req_front_sample[IDX_W-1:0];
   assign lo_idx    = (back_idx < front_idx) ? back_idx : front_idx;
   assign hi_idx    = (back_idx < front_idx) ? front_idx : back_idx;
   assign packed_entry = {req_entry_alpha, req_entry_blue, req_entry_green, req_entry_red};

   // Advance the running integrals; restart them at index zero.
   always_comb begin
      for (int c = 0; c < NUM_CHAN; c++) begin
         if (idx == '0) begin
            sums_in[c] = '0;
         end else begin
            sums_in[c] = sums_ff[c]
                       + SUM_W'(prev_ff[c*CHAN_W +: CHAN_W])
                       + SUM_W'(packed_entry[c*CHAN_W +: CHAN_W]);
         end
      end
      prev_in = packed_entry;
      wr_word[ENTRY_W-1:0] = packed_entry;
      for (int c = 0; c < NUM_CHAN; c++) begin
         wr_word[ENTRY_W + c*SUM_W +: SUM_W] = sums_in[c];
      end
   end

   ptt_ram #(.WIDTH(WORD_W), .ADDR_W(IDX_W)) u_ram (
      .clock     (clock),
      .wr_en     (load_acc),
      .wr_addr   (idx),
      .wr_data   (wr_word),
      .rd_addr_a (lo_idx),
      .rd_addr_b (hi_idx),
      .rd_data_a (rd_lo),
      .rd_data_b (rd_hi));

   // Build the divider lanes: a difference that is not positive divides zero.
   always_comb begin
      div_req.start   = (state_ff == ST_READ) && !equal_ff;
      div_req.divisor = dvsr_ff;
      for (int c = 0; c < NUM_CHAN; c++) begin
         diff[c] = {1'b0, rd_hi[ENTRY_W + c*SUM_W +: SUM_W]}
                 - {1'b0, rd_lo[ENTRY_W + c*SUM_W +: SUM_W]};
         if (!diff[c][SUM_W] && (diff[c] != '0)) begin
            div_req.dividend[c] = {diff[c][SUM_W-1:0], {ALPHA_FRAC_BITS{1'b0}}};
         end else begin
            div_req.dividend[c] = '0;
         end
      end
   end

   ptt_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp));

   always_comb begin
      state_in     = state_ff;
      dvsr_in      = dvsr_ff;
      equal_in     = equal_ff;
      rsp_valid_in = rsp_valid_ff;
      seg_in       = seg_ff;
      case (state_ff)
         ST_IDLE: begin
            if (query_acc) begin
               dvsr_in  = {hi_idx - lo_idx, 1'b0};
               equal_in = lo_idx == hi_idx;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (equal_ff) begin
               // equal samples: hand back the stored entry
               for (int c = 0; c < NUM_CHAN; c++) begin
                  seg_in[c] = rd_lo[c*CHAN_W +: CHAN_W];
               end
               rsp_valid_in = 1'b1;
               state_in     = ST_OUT;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               seg_in       = div_rsp.chan;
               rsp_valid_in = 1'b1;
               state_in     = ST_OUT;
            end
         end
         ST_OUT: begin
            // hold the result beat until it is taken
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         prev_ff      <= '0;
         for (int c = 0; c < NUM_CHAN; c++) begin
            sums_ff[c] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (load_acc) begin
            prev_ff <= prev_in;
            sums_ff <= sums_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      dvsr_ff  <= dvsr_in;
      equal_ff <= equal_in;
      seg_ff   <= seg_in;
   end

   assign req_stall     = state_ff != ST_IDLE;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_seg_red   = seg_ff[0];
   assign rsp_seg_green = seg_ff[1];
   assign rsp_seg_blue  = seg_ff[2];
   assign rsp_seg_alpha = seg_ff[3];

   `PTT_ASSERT_IMPL(a_rsp_only_in_out, rsp_valid_ff, state_ff == ST_OUT, "result beat outside output state")
   `PTT_ASSERT_NEXT(a_query_reads, query_acc, state_ff == ST_READ, "query did not start a read")
   `PTT_ASSERT_IMPL(a_done_in_div, div_rsp.done, state_ff == ST_DIV, "divider finished while not awaited")

endmodule

// File: tb/preintegrated_transfer_table_tb.sv
module preintegrated_transfer_table_tb;
   import ptt_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int ITEM_TARGET    = 1350;

   typedef struct {
      logic       opcode;
      logic [7:0] index;
      logic [7:0] chan [4];
      logic [7:0] back;
      logic [7:0] front;
   } table_item_type;

   typedef struct {
      logic [7:0] chan [4];
   } segment_color_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic       req_opcode = OP_LOAD;
   logic [7:0] req_entry_index = '0;
   logic [7:0] req_entry_red = '0;
   logic [7:0] req_entry_green = '0;
   logic [7:0] req_entry_blue = '0;
   logic [7:0] req_entry_alpha = '0;
   logic [7:0] req_back_sample = '0;
   logic [7:0] req_front_sample = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_seg_red;
   logic [7:0] rsp_seg_green;
   logic [7:0] rsp_seg_blue;
   logic [7:0] rsp_seg_alpha;

   preintegrated_transfer_table dut (.*);

   always #6 clock = ~clock;

   // Beats waiting to be offered, and segment colors waiting to come back.
   table_item_type    pending_beats [$];
   segment_color_type expected_colors [$];

   // Own copy of the table state.
   logic [7:0]  stored_chan [256][4];
   logic [16:0] prefix_sum [4][256];
   logic [7:0]  last_loaded [4];
   logic [16:0] running_prefix [4];
   longint      opacity_step [256];

   // Indexes already written, so queries never touch an empty slot.
   bit          slot_written [256];
   logic [7:0]  written_slots [$];

   int  mismatch_count = 0;
   int  idle_cycles = 0;
   int  colors_taken = 0;
   bit  req_taken = 1'b0;
   bit  rsp_taken = 1'b0;
   bit  stimulus_done = 1'b0;
   int  send_gap = 0;
   int  recv_gap = 0;
   int  long_hold = 0;
   bit  send_burst = 1'b0;
   int  burst_left = 0;

   // Opacity steps: ceil(2^F * 255 * ln(256 / (256 - k))).
   initial begin
      opacity_step[0] = 0;
      for (int k = 1; k < 256; k++)
         opacity_step[k] = longint'($ceil(real'(255 << ALPHA_FRAC_BITS) *
                                          $ln(256.0 / (256.0 - real'(k)))));
   end

   // Apply one accepted beat to the table copy; return 1 when it yields a color.
   function automatic bit integrate_beat(input table_item_type it,
                                         output segment_color_type col);
      logic [7:0] lo, hi;
      longint     diff, twice_dist, xq, level;
      if (it.opcode == OP_LOAD) begin
         for (int c = 0; c < 4; c++) begin
            if (it.index == 0)
               running_prefix[c] = '0;
            else
               running_prefix[c] = running_prefix[c] + 17'(last_loaded[c]) + 17'(it.chan[c]);
            prefix_sum[c][it.index] = running_prefix[c];
            stored_chan[it.index][c] = it.chan[c];
            last_loaded[c] = it.chan[c];
         end
         return 1'b0;
      end
      lo = (it.back < it.front) ? it.back : it.front;
      hi = (it.back < it.front) ? it.front : it.back;
      for (int c = 0; c < 4; c++) begin
         if (lo == hi) begin
            col.chan[c] = stored_chan[lo][c];
         end else begin
            diff = longint'(prefix_sum[c][hi]) - longint'(prefix_sum[c][lo]);
            twice_dist = 2 * longint'(hi - lo);
            col.chan[c] = '0;
            if (diff > 0 && c < 3) begin
               col.chan[c] = (diff / twice_dist > 255) ? 8'd255 : 8'(diff / twice_dist);
            end else if (diff > 0) begin
               xq = (diff << ALPHA_FRAC_BITS) / twice_dist;
               if (xq > (64'd1 << (8 + ALPHA_FRAC_BITS)) - 1)
                  xq = (64'd1 << (8 + ALPHA_FRAC_BITS)) - 1;
               level = 0;
               for (int k = 1; k < 256; k++)
                  if (xq >= opacity_step[k]) level++;
               col.chan[c] = 8'(level);
            end
         end
      end
      return 1'b1;
   endfunction

   // Queue a load beat; mark the slot as safe to query.
   task automatic push_load(input logic [7:0] idx, input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b, input logic [7:0] a);
      table_item_type it;
      it.opcode = OP_LOAD;
      it.index = idx;
      it.chan[0] = r;
      it.chan[1] = g;
      it.chan[2] = b;
      it.chan[3] = a;
      it.back = 8'($urandom);
      it.front = 8'($urandom);
      pending_beats.push_back(it);
      if (!slot_written[idx]) begin
         slot_written[idx] = 1'b1;
         written_slots.push_back(idx);
      end
   endtask

   // Queue a query beat; entry fields carry noise the block must ignore.
   task automatic push_query(input logic [7:0] back, input logic [7:0] front);
      table_item_type it;
      it.opcode = OP_QUERY;
      it.index = 8'($urandom);
      for (int c = 0; c < 4; c++) it.chan[c] = 8'($urandom);
      it.back = back;
      it.front = front;
      pending_beats.push_back(it);
   endtask

   function automatic logic [7:0] random_level();
      case ($urandom_range(0, 5))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] any_written();
      return written_slots[$urandom_range(0, written_slots.size() - 1)];
   endfunction

   // Stimulus: directed corners first, then random table builds and queries.
   initial begin
      int table_len;
      int queries;
      for (int i = 0; i < 8; i++)
         push_load(8'(i), (i % 2) ? 8'd255 : 8'd0, 8'd255, 8'd0, (i < 4) ? 8'd255 : 8'd0);
      push_query(8'd0, 8'd7);      // forward segment
      push_query(8'd7, 8'd0);      // swapped samples
      push_query(8'd3, 8'd3);      // equal samples return the entry
      push_query(8'd0, 8'd1);      // both entries at full alpha
      push_query(8'd6, 8'd7);      // zero alpha slope
      // Restart at zero, then jump ahead: stale high integrals give negative spans.
      push_load(8'd0, 8'd1, 8'd1, 8'd1, 8'd1);
      push_load(8'd9, 8'd0, 8'd0, 8'd0, 8'd0);
      push_query(8'd7, 8'd9);
      push_query(8'd9, 8'd1);
      // Load the last slot repeatedly; each load adds to the running sums.
      for (int i = 0; i < 6; i++)
         push_load(8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
      push_query(8'd255, 8'd0);
      push_query(8'd255, 8'd255);

      while (pending_beats.size() < ITEM_TARGET) begin
         table_len = ($urandom_range(0, 7) == 0) ? 255 : $urandom_range(1, 40);
         for (int i = 0; i <= table_len; i++)
            push_load(8'(i), random_level(), random_level(), random_level(), random_level());
         queries = $urandom_range(5, 30);
         for (int i = 0; i < queries; i++) begin
            case ($urandom_range(0, 9))
               0: begin
                  logic [7:0] s;
                  s = any_written();
                  push_query(s, s);
               end
               1: push_load(8'($urandom), random_level(), random_level(),
                            random_level(), random_level());
               default: push_query(any_written(), any_written());
            endcase
         end
      end

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      wait (pending_beats.size() == 0 && !req_valid);
      wait (expected_colors.size() == 0);
      repeat (60) @(posedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // Record acceptances at the rising edge; predict and check there.
   always @(posedge clock) begin
      segment_color_type col;
      segment_color_type want;
      req_taken <= req_valid && !req_stall && !reset;
      rsp_taken <= rsp_valid && !rsp_stall && !reset;
      if (!reset && req_valid && !req_stall) begin
         table_item_type it;
         it.opcode = req_opcode;
         it.index = req_entry_index;
         it.chan[0] = req_entry_red;
         it.chan[1] = req_entry_green;
         it.chan[2] = req_entry_blue;
         it.chan[3] = req_entry_alpha;
         it.back = req_back_sample;
         it.front = req_front_sample;
         if (integrate_beat(it, col))
            expected_colors.push_back(col);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_colors.size() == 0) begin
            $error("result beat with no query outstanding");
            mismatch_count++;
         end else begin
            want = expected_colors.pop_front();
            if (rsp_seg_red !== want.chan[0]) begin
               $error("seg_red expected %0d actual %0d", want.chan[0], rsp_seg_red);
               mismatch_count++;
            end
            if (rsp_seg_green !== want.chan[1]) begin
               $error("seg_green expected %0d actual %0d", want.chan[1], rsp_seg_green);
               mismatch_count++;
            end
            if (rsp_seg_blue !== want.chan[2]) begin
               $error("seg_blue expected %0d actual %0d", want.chan[2], rsp_seg_blue);
               mismatch_count++;
            end
            if (rsp_seg_alpha !== want.chan[3]) begin
               $error("seg_alpha expected %0d actual %0d", want.chan[3], rsp_seg_alpha);
               mismatch_count++;
            end
         end
      end
   end

   // Sender: advance to the next beat once the current one is taken,
   // after a drawn gap; alternate gappy and back-to-back stretches.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_beats.size() > 0) begin
            table_item_type it;
            it = pending_beats.pop_front();
            req_opcode <= it.opcode;
            req_entry_index <= it.index;
            req_entry_red <= it.chan[0];
            req_entry_green <= it.chan[1];
            req_entry_blue <= it.chan[2];
            req_entry_alpha <= it.chan[3];
            req_back_sample <= it.back;
            req_front_sample <= it.front;
            req_valid <= 1'b1;
            if (burst_left == 0) begin
               burst_left <= $urandom_range(20, 80);
               send_burst <= !send_burst;
            end else begin
               burst_left <= burst_left - 1;
            end
            send_gap <= send_burst ? 0 : $urandom_range(0, 7);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: stall a drawn number of cycles before each result; once,
   // hold off for a long stretch while the sender keeps offering beats.
   always @(negedge clock) begin
      if (rsp_taken) begin
         colors_taken++;
         recv_gap = send_burst ? 0 : $urandom_range(0, 7);
         if (colors_taken == 150) long_hold = 400;
      end
      if (long_hold > 0) begin
         long_hold--;
         rsp_stall <= 1'b1;
      end else if (recv_gap > 0) begin
         recv_gap--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Watchdog: end the run if nothing moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/ptt_pkg.sv
hw/rtl/ptt_ram.sv
hw/rtl/ptt_div.sv
hw/rtl/preintegrated_transfer_table.sv
tb/preintegrated_transfer_table_tb.sv
